### hdl/rsa_char_modexp_macros.svh
// Assertion macros shared by the modular exponentiation block.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef RSA_CHAR_MODEXP_MACROS_SVH
`define RSA_CHAR_MODEXP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rcm_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Used by the microcode ROM, the sequencer, the datapath and the top level.
package rcm_pkg;

  // Field and datapath widths.
  localparam int DATA_W       = 32;
  localparam int MOD_W        = 31;
  localparam int CNT_W        = 6;
  localparam int RED_STEPS    = 32;
  localparam int MUL_STEPS    = 32;
  localparam int EXP_BITS_DEF = 32;
  localparam int PADDR_W      = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENC_EXP = 2'd0;
  localparam logic [1:0] REG_ENC_MOD = 2'd1;
  localparam logic [1:0] REG_DEC_EXP = 2'd2;
  localparam logic [1:0] REG_DEC_MOD = 2'd3;

  // Microprogram addresses.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_REDUCE   = 4'd1;
  localparam logic [PC_W-1:0] PC_SQ_INIT  = 4'd2;
  localparam logic [PC_W-1:0] PC_BIT      = 4'd3;
  localparam logic [PC_W-1:0] PC_ACC_MUL  = 4'd4;
  localparam logic [PC_W-1:0] PC_ACC_WB   = 4'd5;
  localparam logic [PC_W-1:0] PC_SQ_SETUP = 4'd6;
  localparam logic [PC_W-1:0] PC_SQ_MUL   = 4'd7;
  localparam logic [PC_W-1:0] PC_SQ_WB    = 4'd8;
  localparam logic [PC_W-1:0] PC_DELIVER  = 4'd9;
  localparam logic [PC_W-1:0] PC_RETURN   = 4'd10;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RED_STEP,
    OP_SQ_FROM_REM,
    OP_MUL_ACC_SETUP,
    OP_MUL_STEP,
    OP_ACC_WB_SQ_SETUP,
    OP_MUL_SQ_SETUP,
    OP_SQ_WB,
    OP_DELIVER
  } op_t;

  // Jump conditions; a true condition loads the target, else the step advances.
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_IN,
    C_CNT_MORE,
    C_EBIT_ZERO,
    C_EBITS_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  // Flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic in_wait;
    logic cnt_more;
    logic ebit_zero;
    logic ebits_more;
    logic out_busy;
  } dp_status_t;

endpackage

### hdl/rsa_char_modexp.sv
// From the input beat to the result beat, the block reduces the base and then runs
// one square-and-multiply round per exponent bit on the single shift-and-add
// product unit, which steps one multiplier bit a cycle.
// One item at a time; the next input beat is taken at the idle step that follows
// the return step after the result is loaded into the output register. Reset
// leaves the block idle with exponents 0 and moduli 1; no clearing pass is needed.
`include "rsa_char_modexp_macros.svh"

module rsa_char_modexp #(
  parameter int EXP_BITS = rcm_pkg::EXP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [rcm_pkg::DATA_W-1:0]     in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rcm_pkg::DATA_W-1:0]     out_result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rcm_pkg::PADDR_W-1:0]    paddr,
  input  logic [rcm_pkg::DATA_W-1:0]     pwdata,
  output logic [rcm_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  logic [rcm_pkg::DATA_W-1:0] enc_exp_r, enc_exp_nxt;
  logic [rcm_pkg::MOD_W-1:0]  enc_mod_r, enc_mod_nxt;
  logic [rcm_pkg::DATA_W-1:0] dec_exp_r, dec_exp_nxt;
  logic [rcm_pkg::MOD_W-1:0]  dec_mod_r, dec_mod_nxt;
  logic [1:0]                 reg_idx;
  logic                       wr_en;
  logic [EXP_BITS-1:0]        sel_exp;
  logic [rcm_pkg::MOD_W-1:0]  sel_mod;
  rcm_pkg::ucw_t              ctrl;
  rcm_pkg::dp_status_t        status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration register writes.
  always_comb begin
    enc_exp_nxt = enc_exp_r;
    enc_mod_nxt = enc_mod_r;
    dec_exp_nxt = dec_exp_r;
    dec_mod_nxt = dec_mod_r;
    if (wr_en) begin
      case (reg_idx)
        rcm_pkg::REG_ENC_EXP: enc_exp_nxt = pwdata;
        rcm_pkg::REG_ENC_MOD: enc_mod_nxt = pwdata[rcm_pkg::MOD_W-1:0];
        rcm_pkg::REG_DEC_EXP: dec_exp_nxt = pwdata;
        rcm_pkg::REG_DEC_MOD: dec_mod_nxt = pwdata[rcm_pkg::MOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_exp_r <= '0;
      enc_mod_r <= rcm_pkg::MOD_W'(1);
      dec_exp_r <= '0;
      dec_mod_r <= rcm_pkg::MOD_W'(1);
    end else begin
      enc_exp_r <= enc_exp_nxt;
      enc_mod_r <= enc_mod_nxt;
      dec_exp_r <= dec_exp_nxt;
      dec_mod_r <= dec_mod_nxt;
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      rcm_pkg::REG_ENC_EXP: prdata = enc_exp_r;
      rcm_pkg::REG_ENC_MOD: prdata = {1'b0, enc_mod_r};
      rcm_pkg::REG_DEC_EXP: prdata = dec_exp_r;
      rcm_pkg::REG_DEC_MOD: prdata = {1'b0, dec_mod_r};
      default:              prdata = '0;
    endcase
  end

  // Key pair chosen by the action of the incoming beat.
  assign sel_exp = in_action ? dec_exp_r[EXP_BITS-1:0] : enc_exp_r[EXP_BITS-1:0];
  assign sel_mod = in_action ? dec_mod_r : enc_mod_r;

  rcm_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  rcm_datapath #(
    .EXP_BITS (EXP_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .status     (status),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_value   (in_value),
    .sel_exp    (sel_exp),
    .sel_mod    (sel_mod),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  // An accepted beat starts a computation, so the input must stall next cycle.
  `RCM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")
  // A delivery step with a free output slot must present a result.
  `RCM_ASSERT_NEXT(a_deliver_sets_valid, ctrl.op == rcm_pkg::OP_DELIVER && !status.out_busy, out_valid, "result lost at delivery")
  // Input is only taken at the idle step of the program.
  `RCM_ASSERT_NOW(a_accept_at_idle, in_valid && !in_stall, ctrl.op == rcm_pkg::OP_LOAD, "input taken outside idle step")

endmodule

### hdl/rcm_ucode_rom.sv
// Microcode ROM: one control word per program step.
// Depends on rcm_pkg for the control word layout and step addresses.
module rcm_ucode_rom (
  input  logic [rcm_pkg::PC_W-1:0] addr,
  output rcm_pkg::ucw_t            word
);

  // Program: load, reduce the base, one square-and-multiply round per exponent bit, deliver.
  always_comb begin
    case (addr)
      rcm_pkg::PC_IDLE:
        word = '{rcm_pkg::OP_LOAD, rcm_pkg::C_NO_IN, rcm_pkg::PC_IDLE};
      rcm_pkg::PC_REDUCE:
        word = '{rcm_pkg::OP_RED_STEP, rcm_pkg::C_CNT_MORE, rcm_pkg::PC_REDUCE};
      rcm_pkg::PC_SQ_INIT:
        word = '{rcm_pkg::OP_SQ_FROM_REM, rcm_pkg::C_NONE, rcm_pkg::PC_IDLE};
      rcm_pkg::PC_BIT:
        word = '{rcm_pkg::OP_MUL_ACC_SETUP, rcm_pkg::C_EBIT_ZERO, rcm_pkg::PC_SQ_SETUP};
      rcm_pkg::PC_ACC_MUL:
        word = '{rcm_pkg::OP_MUL_STEP, rcm_pkg::C_CNT_MORE, rcm_pkg::PC_ACC_MUL};
      rcm_pkg::PC_ACC_WB:
        word = '{rcm_pkg::OP_ACC_WB_SQ_SETUP, rcm_pkg::C_ALWAYS, rcm_pkg::PC_SQ_MUL};
      rcm_pkg::PC_SQ_SETUP:
        word = '{rcm_pkg::OP_MUL_SQ_SETUP, rcm_pkg::C_NONE, rcm_pkg::PC_IDLE};
      rcm_pkg::PC_SQ_MUL:
        word = '{rcm_pkg::OP_MUL_STEP, rcm_pkg::C_CNT_MORE, rcm_pkg::PC_SQ_MUL};
      rcm_pkg::PC_SQ_WB:
        word = '{rcm_pkg::OP_SQ_WB, rcm_pkg::C_EBITS_MORE, rcm_pkg::PC_BIT};
      rcm_pkg::PC_DELIVER:
        word = '{rcm_pkg::OP_DELIVER, rcm_pkg::C_OUT_BUSY, rcm_pkg::PC_DELIVER};
      rcm_pkg::PC_RETURN:
        word = '{rcm_pkg::OP_NOP, rcm_pkg::C_ALWAYS, rcm_pkg::PC_IDLE};
      default:
        word = '{rcm_pkg::OP_NOP, rcm_pkg::C_ALWAYS, rcm_pkg::PC_IDLE};
    endcase
  end

endmodule

### hdl/rcm_datapath.sv
// Datapath: base reduction, shift-and-add modular products, result register.
// Depends on rcm_pkg; driven by control words from rcm_sequencer.
module rcm_datapath #(
  parameter int EXP_BITS = rcm_pkg::EXP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rcm_pkg::ucw_t                 ctrl,
  output rcm_pkg::dp_status_t           status,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [rcm_pkg::DATA_W-1:0]    in_value,
  input  logic [EXP_BITS-1:0]           sel_exp,
  input  logic [rcm_pkg::MOD_W-1:0]     sel_mod,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rcm_pkg::DATA_W-1:0]    out_result
);

  localparam int EBITS_W = $clog2(EXP_BITS + 1);
  localparam int MW = rcm_pkg::MOD_W;
  localparam int DW = rcm_pkg::DATA_W;
  localparam int CW = rcm_pkg::CNT_W;

  logic                act_r, act_nxt;
  logic [DW-1:0]       base_r, base_nxt;
  logic [MW-1:0]       mod_r, mod_nxt;
  logic [MW-1:0]       rem_r, rem_nxt;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic [EBITS_W-1:0]  ebits_r, ebits_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [MW-1:0]       acc_r, acc_nxt;
  logic [MW-1:0]       sq_r, sq_nxt;
  logic [MW-1:0]       dbl_r, dbl_nxt;
  logic [MW-1:0]       mb_r, mb_nxt;
  logic [MW-1:0]       macc_r, macc_nxt;
  logic [DW-1:0]       out_result_r, out_result_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [MW-1:0] mod_eff;
  logic [DW-1:0] mod_ext;
  logic [DW-1:0] red_t, red_d, sum_t, sum_d, dbl_t, dbl_d;
  logic [MW-1:0] red_res, sum_res, dbl_res;
  logic          accept, out_busy;

  // A zero modulus acts as one.
  assign mod_eff = (sel_mod == '0) ? MW'(1) : sel_mod;
  assign mod_ext = {1'b0, mod_r};

  // Reduction step: shift one base bit into the remainder, subtract the modulus at most once.
  assign red_t   = {rem_r, base_r[DW-1]};
  assign red_d   = red_t - mod_ext;
  assign red_res = (red_t >= mod_ext) ? red_d[MW-1:0] : red_t[MW-1:0];

  // Product step: conditional add and doubling, each kept below the modulus.
  assign sum_t   = {1'b0, macc_r} + {1'b0, dbl_r};
  assign sum_d   = sum_t - mod_ext;
  assign sum_res = (sum_t >= mod_ext) ? sum_d[MW-1:0] : sum_t[MW-1:0];
  assign dbl_t   = {dbl_r, 1'b0};
  assign dbl_d   = dbl_t - mod_ext;
  assign dbl_res = (dbl_t >= mod_ext) ? dbl_d[MW-1:0] : dbl_t[MW-1:0];

  assign out_busy = out_valid_r && out_stall;
  assign in_stall = (ctrl.op != rcm_pkg::OP_LOAD);
  assign accept   = in_valid && !in_stall;

  // Status flags for the sequencer's branch decisions.
  assign status.in_wait    = !in_valid;
  assign status.cnt_more   = (cnt_r != CW'(1));
  assign status.ebit_zero  = !exp_r[0];
  assign status.ebits_more = (ebits_r != EBITS_W'(1));
  assign status.out_busy   = out_busy;

  // Register updates selected by the current operation.
  always_comb begin
    act_nxt        = act_r;
    base_nxt       = base_r;
    mod_nxt        = mod_r;
    rem_nxt        = rem_r;
    exp_nxt        = exp_r;
    ebits_nxt      = ebits_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    sq_nxt         = sq_r;
    dbl_nxt        = dbl_r;
    mb_nxt         = mb_r;
    macc_nxt       = macc_r;
    out_result_nxt = out_result_r;
    out_valid_nxt  = out_valid_r && out_stall;
    case (ctrl.op)
      rcm_pkg::OP_LOAD: begin
        if (accept) begin
          act_nxt  = in_action;
          base_nxt = in_value;
          mod_nxt  = mod_eff;
          exp_nxt  = sel_exp;
          acc_nxt  = (mod_eff == MW'(1)) ? '0 : MW'(1);
          rem_nxt  = '0;
          cnt_nxt  = CW'(rcm_pkg::RED_STEPS);
        end
      end
      rcm_pkg::OP_RED_STEP: begin
        rem_nxt  = red_res;
        base_nxt = {base_r[DW-2:0], 1'b0};
        cnt_nxt  = cnt_r - CW'(1);
      end
      rcm_pkg::OP_SQ_FROM_REM: begin
        sq_nxt    = rem_r;
        ebits_nxt = EBITS_W'(EXP_BITS);
      end
      rcm_pkg::OP_MUL_ACC_SETUP: begin
        dbl_nxt  = acc_r;
        mb_nxt   = sq_r;
        macc_nxt = '0;
        cnt_nxt  = CW'(rcm_pkg::MUL_STEPS);
      end
      rcm_pkg::OP_MUL_STEP: begin
        if (mb_r[0]) begin
          macc_nxt = sum_res;
        end
        dbl_nxt = dbl_res;
        mb_nxt  = {1'b0, mb_r[MW-1:1]};
        cnt_nxt = cnt_r - CW'(1);
      end
      rcm_pkg::OP_ACC_WB_SQ_SETUP: begin
        acc_nxt  = macc_r;
        dbl_nxt  = sq_r;
        mb_nxt   = sq_r;
        macc_nxt = '0;
        cnt_nxt  = CW'(rcm_pkg::MUL_STEPS);
      end
      rcm_pkg::OP_MUL_SQ_SETUP: begin
        dbl_nxt  = sq_r;
        mb_nxt   = sq_r;
        macc_nxt = '0;
        cnt_nxt  = CW'(rcm_pkg::MUL_STEPS);
      end
      rcm_pkg::OP_SQ_WB: begin
        sq_nxt    = macc_r;
        exp_nxt   = exp_r >> 1;
        ebits_nxt = ebits_r - EBITS_W'(1);
      end
      rcm_pkg::OP_DELIVER: begin
        if (!out_busy) begin
          out_result_nxt = act_r ? {24'd0, acc_r[7:0]} : {1'b0, acc_r};
          out_valid_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state is reset; working registers are loaded before use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    base_r       <= base_nxt;
    mod_r        <= mod_nxt;
    rem_r        <= rem_nxt;
    exp_r        <= exp_nxt;
    ebits_r      <= ebits_nxt;
    cnt_r        <= cnt_nxt;
    acc_r        <= acc_nxt;
    sq_r         <= sq_nxt;
    dbl_r        <= dbl_nxt;
    mb_r         <= mb_nxt;
    macc_r       <= macc_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

### hdl/rcm_sequencer.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on rcm_pkg and rcm_ucode_rom.
module rcm_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  rcm_pkg::dp_status_t status,
  output rcm_pkg::ucw_t       ctrl
);

  logic [rcm_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     take;

  rcm_ucode_rom u_rom (
    .addr (pc_r),
    .word (ctrl)
  );

  // Evaluate the jump condition of the current control word.
  always_comb begin
    case (ctrl.cond)
      rcm_pkg::C_NONE:       take = 1'b0;
      rcm_pkg::C_ALWAYS:     take = 1'b1;
      rcm_pkg::C_NO_IN:      take = status.in_wait;
      rcm_pkg::C_CNT_MORE:   take = status.cnt_more;
      rcm_pkg::C_EBIT_ZERO:  take = status.ebit_zero;
      rcm_pkg::C_EBITS_MORE: take = status.ebits_more;
      rcm_pkg::C_OUT_BUSY:   take = status.out_busy;
      default:               take = 1'b1;
    endcase
  end

  assign pc_nxt = take ? ctrl.target : pc_r + rcm_pkg::PC_W'(1);

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rcm_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
